// ===== hw/rtl/m2e_pkg.sv =====
// ----------------------------------------------------------------------------
// m2e_pkg
// Shared widths, class codes and the queue record for the 2x2 eigenvalue block.
// ----------------------------------------------------------------------------
package m2e_pkg;

	localparam int ENTRY_W = 32;
	localparam int FRAC_W  = 16;
	localparam int OUT_W   = ENTRY_W + 2;
	localparam int BAND_W  = 16;
	localparam int TR_W    = ENTRY_W + 1;
	localparam int PROD_W  = 2 * ENTRY_W;
	localparam int DET_W   = PROD_W + 1;
	localparam int SQ_W    = 2 * TR_W;
	localparam int DISC_W  = PROD_W + 4;
	localparam int ROOT_W  = DISC_W / 2;
	localparam int REM_W   = ROOT_W + 1;
	localparam int SUM_W   = ROOT_W + 2;
	localparam int H_W     = ROOT_W + 1;
	localparam int DIV_W   = ROOT_W;
	localparam int QUOT_W  = ROOT_W + 4;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_POS,
		CLS_NEG
	} cls_t;

	typedef struct packed {
		logic                     cplx;
		cls_t                     cls;
		logic signed [TR_W-1:0]   tr;
		logic signed [DET_W-1:0]  det;
		logic        [DISC_W-1:0] disc;
	} job_t;

endpackage

// ===== hw/rtl/m2e_front.sv =====
// ----------------------------------------------------------------------------
// m2e_front
// Trace, determinant and discriminant; classifies each request by trace sign against the band.
// ----------------------------------------------------------------------------
module m2e_front import m2e_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [ENTRY_W-1:0] entry_row0_col0,
	input  logic signed [ENTRY_W-1:0] entry_row0_col1,
	input  logic signed [ENTRY_W-1:0] entry_row1_col0,
	input  logic signed [ENTRY_W-1:0] entry_row1_col1,
	input  logic        [BAND_W-1:0]  band,
	output logic                      push,
	input  logic                      q_ready,
	output job_t                      job
);

	logic                      v_s1, v_s2, v_s3;
	logic signed [PROD_W-1:0]  p_ad_s1, p_cb_s1;
	logic signed [TR_W-1:0]    tr_s1, tr_s2;
	logic signed [DET_W-1:0]   det_s2;
	logic signed [SQ_W-1:0]    trsq_s2;
	cls_t                      cls_s2;
	job_t                      job_s3;
	logic                      ce;
	logic signed [TR_W-1:0]    band_ext;
	logic signed [DISC_W-1:0]  disc;
	cls_t                      cls_c;

	assign ce       = !v_s3 || q_ready;
	assign in_stall = !ce;
	assign push     = v_s3 && q_ready;
	assign job      = job_s3;
	assign band_ext = {{(TR_W-BAND_W){1'b0}}, band};

	always_comb begin
		if (tr_s1 < -band_ext)
			cls_c = CLS_NEG;
		else if (tr_s1 > band_ext)
			cls_c = CLS_POS;
		else
			cls_c = CLS_ZERO;
	end

	assign disc = {{(DISC_W-SQ_W){trsq_s2[SQ_W-1]}}, trsq_s2}
		- {det_s2[DET_W-1], det_s2, 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (ce) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			p_ad_s1     <= entry_row0_col0 * entry_row1_col1;
			p_cb_s1     <= entry_row1_col0 * entry_row0_col1;
			tr_s1       <= {entry_row0_col0[ENTRY_W-1], entry_row0_col0}
				+ {entry_row1_col1[ENTRY_W-1], entry_row1_col1};
			det_s2      <= {p_ad_s1[PROD_W-1], p_ad_s1} - {p_cb_s1[PROD_W-1], p_cb_s1};
			trsq_s2     <= tr_s1 * tr_s1;
			tr_s2       <= tr_s1;
			cls_s2      <= cls_c;
			job_s3.cplx <= disc[DISC_W-1];
			job_s3.cls  <= cls_s2;
			job_s3.tr   <= tr_s2;
			job_s3.det  <= det_s2;
			job_s3.disc <= disc;
		end
	end

endmodule

// ===== hw/rtl/m2e_queue.sv =====
// ----------------------------------------------------------------------------
// m2e_queue
// Short queue of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module m2e_queue import m2e_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic ready,
	input  logic pop,
	output logic valid,
	output job_t rd_job
);

	job_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q, rd_q;
	logic [QPTR_W:0]    cnt_q;

	assign ready  = cnt_q != QDEPTH[QPTR_W:0];
	assign valid  = cnt_q != '0;
	assign rd_job = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wr_job;
	end

endmodule

// ===== hw/rtl/m2e_back.sv =====
// ----------------------------------------------------------------------------
// m2e_back
// Pipelined square root, stable root selection and pipelined division.
// ----------------------------------------------------------------------------
module m2e_back import m2e_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  job_t                    q_job,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] eig_first,
	output logic signed [OUT_W-1:0] eig_second,
	output logic                    is_complex
);

	typedef struct packed {
		logic                     cplx;
		cls_t                     cls;
		logic signed [TR_W-1:0]   tr;
		logic signed [DET_W-1:0]  det;
		logic        [DISC_W-1:0] rad;
		logic        [REM_W-1:0]  rem;
		logic        [ROOT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic                     cplx;
		cls_t                     cls;
		logic signed [H_W-1:0]    h;
		logic        [ROOT_W-2:0] shalf;
		logic                     qneg;
		logic                     dzero;
		logic        [DIV_W-1:0]  dmag;
		logic        [DIV_W-1:0]  rem;
		logic        [QUOT_W-1:0] num;
		logic        [QUOT_W-1:0] quot;
	} dv_t;

	function automatic sq_t sq_step(input sq_t a);
		logic [REM_W+1:0] t;
		logic [REM_W+1:0] trial;
		sq_t              r;
		r     = a;
		t     = {a.rem, a.rad[DISC_W-1 -: 2]};
		trial = {1'b0, a.root, 2'b01};
		r.rad = {a.rad[DISC_W-3:0], 2'b00};
		if (t >= trial) begin
			r.rem  = REM_W'(t - trial);
			r.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = REM_W'(t);
			r.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic dv_t dv_step(input dv_t a);
		logic [DIV_W:0] t;
		dv_t            r;
		r     = a;
		t     = {a.rem, a.num[QUOT_W-1]};
		r.num = {a.num[QUOT_W-2:0], 1'b0};
		if (t >= {1'b0, a.dmag}) begin
			r.rem  = DIV_W'(t - {1'b0, a.dmag});
			r.quot = {a.quot[QUOT_W-2:0], 1'b1};
		end else begin
			r.rem  = DIV_W'(t);
			r.quot = {a.quot[QUOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	logic                     ce;
	logic [ROOT_W-1:0]        sv_s;
	sq_t                      sq_s [ROOT_W];
	logic [QUOT_W-1:0]        dvv_s;
	dv_t                      dv_s [QUOT_W];
	logic                     hv_s;
	dv_t                      h_s;
	sq_t                      sq_in, sq_last;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  half;
	logic signed [H_W-1:0]    h_c;
	logic        [DET_W-1:0]  nmag;
	dv_t                      h_c_rec;
	dv_t                      dv_last;
	logic        [OUT_W-1:0]  qmag, qval, hval, sval;
	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  e1_q, e2_q;
	logic                     cplx_q;

	assign ce         = !out_valid_q || !out_stall;
	assign pop        = ce && q_valid;
	assign out_valid  = out_valid_q;
	assign eig_first  = e1_q;
	assign eig_second = e2_q;
	assign is_complex = cplx_q;

	always_comb begin
		sq_in      = '0;
		sq_in.cplx = q_job.cplx;
		sq_in.cls  = q_job.cls;
		sq_in.tr   = q_job.tr;
		sq_in.det  = q_job.det;
		sq_in.rad  = q_job.disc;
	end

	assign sq_last = sq_s[ROOT_W-1];

	always_comb begin
		if (sq_last.cls == CLS_NEG)
			sum = SUM_W'(sq_last.tr) - $signed({2'b00, sq_last.root});
		else
			sum = SUM_W'(sq_last.tr) + $signed({2'b00, sq_last.root});
		half = (sum + $signed({{(SUM_W-1){1'b0}}, sum[SUM_W-1]})) >>> 1;
		h_c  = H_W'(half);
		nmag = sq_last.det[DET_W-1] ? DET_W'(-sq_last.det) : DET_W'(sq_last.det);
		h_c_rec       = '0;
		h_c_rec.cplx  = sq_last.cplx;
		h_c_rec.cls   = sq_last.cls;
		h_c_rec.h     = h_c;
		h_c_rec.shalf = sq_last.root[ROOT_W-1:1];
		h_c_rec.qneg  = sq_last.det[DET_W-1] ^ h_c[H_W-1];
		h_c_rec.dzero = h_c == '0;
		h_c_rec.dmag  = h_c[H_W-1] ? DIV_W'(-h_c) : DIV_W'(h_c);
		h_c_rec.rem   = DIV_W'(nmag >> QUOT_W);
		h_c_rec.num   = nmag[QUOT_W-1:0];
	end

	assign dv_last = dv_s[QUOT_W-1];

	always_comb begin
		qmag = dv_last.dzero ? '0 : dv_last.quot[OUT_W-1:0];
		qval = dv_last.qneg ? OUT_W'(-qmag) : qmag;
		hval = dv_last.h[OUT_W-1:0];
		sval = {1'b0, dv_last.shalf};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_s        <= '0;
			hv_s        <= 1'b0;
			dvv_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (ce) begin
			sv_s        <= {sv_s[ROOT_W-2:0], q_valid};
			hv_s        <= sv_s[ROOT_W-1];
			dvv_s       <= {dvv_s[QUOT_W-2:0], hv_s};
			out_valid_q <= dvv_s[QUOT_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sq_s[0] <= sq_step(sq_in);
			for (int k = 1; k < ROOT_W; k++)
				sq_s[k] <= sq_step(sq_s[k-1]);
			h_s      <= h_c_rec;
			dv_s[0]  <= dv_step(h_s);
			for (int k = 1; k < QUOT_W; k++)
				dv_s[k] <= dv_step(dv_s[k-1]);
			cplx_q <= dv_last.cplx;
			if (dv_last.cplx) begin
				e1_q <= '0;
				e2_q <= '0;
			end else begin
				unique case (dv_last.cls)
					CLS_POS: begin
						e1_q <= hval;
						e2_q <= qval;
					end
					CLS_NEG: begin
						e1_q <= qval;
						e2_q <= hval;
					end
					default: begin
						e1_q <= sval;
						e2_q <= -sval;
					end
				endcase
			end
		end
	end

endmodule

// ===== hw/rtl/matrix2x2_eigenvalues.sv =====
// ----------------------------------------------------------------------------
// matrix2x2_eigenvalues
// Real eigenvalues of a signed Q16.16 2x2 matrix by the stable quadratic form.
// ----------------------------------------------------------------------------
// One matrix is taken per clock and one result leaves per clock when neither
// side stalls. A request passes a three-stage front (products, determinant and
// trace square, discriminant) into a four-entry queue, then a back pipeline of
// 34 square-root stages, one root selection stage, 38 divider stages and an
// output register. The band register is written over the cfg port, which is
// always ready.
module matrix2x2_eigenvalues import m2e_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic        [BAND_W-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [ENTRY_W-1:0] entry_row0_col0,
	input  logic signed [ENTRY_W-1:0] entry_row0_col1,
	input  logic signed [ENTRY_W-1:0] entry_row1_col0,
	input  logic signed [ENTRY_W-1:0] entry_row1_col1,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [OUT_W-1:0]   eig_first,
	output logic signed [OUT_W-1:0]   eig_second,
	output logic                      is_complex
);

	logic [BAND_W-1:0] band_q;
	logic              push, q_ready, q_valid, pop;
	job_t              wr_job, rd_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			band_q <= '0;
		else if (cfg_valid && cfg_ready)
			band_q <= cfg_data;
	end

	m2e_front u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.entry_row0_col0, .entry_row0_col1, .entry_row1_col0, .entry_row1_col1,
		.band(band_q), .push, .q_ready, .job(wr_job)
	);

	m2e_queue u_queue (
		.clk, .arst_n, .push, .wr_job, .ready(q_ready),
		.pop, .valid(q_valid), .rd_job
	);

	m2e_back u_back (
		.clk, .arst_n, .q_valid, .q_job(rd_job), .pop,
		.out_valid, .out_stall, .eig_first, .eig_second, .is_complex
	);

endmodule

// ===== hw/rtl/m2e_checker.sv =====
// ----------------------------------------------------------------------------
// m2e_checker
// Port-level checks for the 2x2 eigenvalue block, bound to the top level.
// ----------------------------------------------------------------------------
module m2e_checker import m2e_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    cfg_ready,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [OUT_W-1:0] eig_first,
	input logic signed [OUT_W-1:0] eig_second,
	input logic                    is_complex
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_cplx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_complex |-> eig_first == '0 && eig_second == '0)
		else $error("complex result with nonzero eigenvalues");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |=> cfg_ready && !out_valid)
		else $error("bad state after reset");

endmodule

bind matrix2x2_eigenvalues m2e_checker u_m2e_checker (
	.clk, .arst_n, .cfg_ready, .out_valid, .out_stall,
	.eig_first, .eig_second, .is_complex
);

// ===== verif/tb_matrix2x2_eigenvalues.sv =====
// ----------------------------------------------------------------------------
// tb_matrix2x2_eigenvalues
// Self-checking bench for the 2x2 eigenvalue block: a built-in predictor works
// out trace, determinant, discriminant and stable-formula roots per request,
// and a checker compares each result in order under random idling and stalls.
// ----------------------------------------------------------------------------
module tb_matrix2x2_eigenvalues;
	import m2e_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY     = 100;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic signed [OUT_W-1:0] e1;
		logic signed [OUT_W-1:0] e2;
		logic                    cplx;
	} eig_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [BAND_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [ENTRY_W-1:0] a00, a01, a10, a11;
	logic out_valid;
	logic out_stall;
	logic signed [OUT_W-1:0] eig_first, eig_second;
	logic is_complex;

	eig_t eig_expected[$];
	logic [BAND_W-1:0] band;
	int errors;
	int idle_cycles;
	int rx_left;
	bit hold_rx;
	bit rx_random;
	bit done;

	matrix2x2_eigenvalues uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.entry_row0_col0(a00), .entry_row0_col1(a01),
		.entry_row1_col0(a10), .entry_row1_col1(a11),
		.out_valid(out_valid), .out_stall(out_stall),
		.eig_first(eig_first), .eig_second(eig_second), .is_complex(is_complex)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [63:0] isqrt(logic [DISC_W-1:0] n);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= {60'd0, n})
				r = c;
		end
		return r;
	endfunction

	function automatic eig_t eigen_predict(logic signed [ENTRY_W-1:0] p, q, r, s);
		logic signed [127:0] tr, det, disc, h, sq, quot;
		logic signed [127:0] bnd;
		eig_t res;
		tr   = 128'(p) + 128'(s);
		det  = 128'(p) * 128'(s) - 128'(r) * 128'(q);
		disc = tr * tr - 4 * det;
		bnd  = {112'd0, band};
		res  = '0;
		if (disc < 0) begin
			res.cplx = 1'b1;
			return res;
		end
		sq = {64'd0, isqrt(disc[DISC_W-1:0])};
		if (tr < -bnd) begin
			h = (tr - sq) / 2;
			quot = (h == 0) ? 128'sd0 : det / h;
			res.e2 = h[OUT_W-1:0];
			res.e1 = quot[OUT_W-1:0];
		end else if (tr > bnd) begin
			h = (tr + sq) / 2;
			quot = (h == 0) ? 128'sd0 : det / h;
			res.e1 = h[OUT_W-1:0];
			res.e2 = quot[OUT_W-1:0];
		end else begin
			h = sq / 2;
			res.e1 = h[OUT_W-1:0];
			res.e2 = OUT_W'(-h);
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// checker
	always @(posedge clk) begin
		eig_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (eig_expected.size() == 0) begin
				report_mismatch("unexpected result", 64'(eig_first), 64'd0);
			end else begin
				w = eig_expected.pop_front();
				if (is_complex !== w.cplx)
					report_mismatch("is_complex", 64'(is_complex), 64'(w.cplx));
				if (eig_first !== w.e1)
					report_mismatch("eig_first", 64'(eig_first), 64'(w.e1));
				if (eig_second !== w.e2)
					report_mismatch("eig_second", 64'(eig_second), 64'(w.e2));
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (hold_rx) begin
			out_stall <= 1'b1;
		end else if (rx_left > 0) begin
			out_stall <= 1'b1;
			rx_left   <= rx_left - 1;
		end else if (!rx_random || $urandom_range(0, 3) != 0) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b1;
			rx_left   <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
				: $urandom_range(0, 2);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid || done
				|| eig_expected.size() == 0 && !in_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("tb_matrix2x2_eigenvalues NOT OK");
			$finish;
		end
	end

	task automatic send_matrix(logic signed [ENTRY_W-1:0] p, q, r, s, bit gaps);
		int g;
		if (gaps && $urandom_range(0, 2) == 0) begin
			g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		a00 <= p;
		a01 <= q;
		a10 <= r;
		a11 <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		eig_expected.push_back(eigen_predict(p, q, r, s));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (eig_expected.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_band(logic [BAND_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		band = v;
		@(posedge clk);
	endtask

	function automatic logic signed [ENTRY_W-1:0] rand_entry();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed(ENTRY_W'($urandom_range(0, 1 << 20))) - (1 << 19);
			2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			3: return $signed(ENTRY_W'($urandom_range(0, 200))) - 100;
			default: return $signed(ENTRY_W'($urandom)) >>> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic test_directed();
		logic signed [ENTRY_W-1:0] mx, mn;
		mx = 32'sh7fffffff;
		mn = 32'sh80000000;
		send_matrix(0, 0, 0, 0, 0);
		send_matrix(mx, mx, mx, mx, 0);
		send_matrix(mn, mn, mn, mn, 0);
		send_matrix(mx, mn, mx, mx, 0);
		send_matrix(mn, mx, mx, mn, 0);
		send_matrix(mx, 0, 0, mn, 0);
		send_matrix(32'sh10000, 0, 0, 32'sh20000, 0);
		send_matrix(-32'sh10000, 0, 0, -32'sh20000, 0);
		send_matrix(0, 32'sh10000, -32'sh10000, 0, 0);
		send_matrix(0, 32'sh10000, 32'sh10000, 0, 0);
		send_matrix(1, 0, 0, 0, 0);
		send_matrix(-1, 0, 0, 0, 0);
		send_matrix(32'sh8000, 0, 0, -32'sh7fff, 0);
		send_matrix(32'sh30000, 32'sh10000, 32'sh10000, 32'sh30000, 0);
		send_matrix(-1, -1, -1, -1, 0);
		send_matrix(32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 0);
		drain();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_matrix(rand_entry(), rand_entry(), rand_entry(), rand_entry(), 1);
	endtask

	task automatic test_band_settings();
		logic [BAND_W-1:0] settings[4];
		settings = '{16'hffff, 16'h0001, 16'h8000, 16'h0000};
		foreach (settings[k]) begin
			write_band(settings[k]);
			send_matrix(settings[k], 0, 0, 0, 0);
			send_matrix(-settings[k], 1, 1, 0, 0);
			send_matrix(settings[k] + 1, 0, 0, 0, 0);
			send_matrix(-settings[k] - 1, 5, -5, 0, 0);
			test_random(274);
			drain();
		end
	endtask

	task automatic test_backpressure();
		rx_random = 1'b0;
		hold_rx = 1'b1;
		fork
			for (int i = 0; i < 120; i++)
				send_matrix(rand_entry(), rand_entry(), rand_entry(), rand_entry(), 0);
			begin
				repeat (300) @(posedge clk);
				hold_rx = 1'b0;
			end
		join
		rx_random = 1'b1;
		drain();
		// burst with no gaps and a steady receiver
		rx_random = 1'b0;
		for (int i = 0; i < 100; i++)
			send_matrix(rand_entry(), rand_entry(), rand_entry(), rand_entry(), 0);
		rx_random = 1'b1;
		drain();
	endtask

	initial begin
		errors = 0;
		idle_cycles = 0;
		rx_left = 0;
		hold_rx = 1'b0;
		rx_random = 1'b1;
		done = 1'b0;
		band = '0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		a00 = '0;
		a01 = '0;
		a10 = '0;
		a11 = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_band_settings();
		test_backpressure();
		done = 1'b1;
		if (errors == 0)
			$display("tb_matrix2x2_eigenvalues OK");
		else
			$display("tb_matrix2x2_eigenvalues NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/m2e_pkg.sv
hw/rtl/m2e_front.sv
hw/rtl/m2e_queue.sv
hw/rtl/m2e_back.sv
hw/rtl/matrix2x2_eigenvalues.sv
hw/rtl/m2e_checker.sv
verif/tb_matrix2x2_eigenvalues.sv
